// ===== src/psrld_pkg.sv =====
// Package for the LED shift register chain driver.
// Holds chain geometry, word widths and sequencer codes; no dependencies.
package psrld_pkg;

  localparam int NUM_LANES     = 4;
  localparam int BITS_PER_LANE = 8;
  localparam int WORD_W        = 32;
  localparam int LANE_DATA_W   = 4;
  localparam int TOP_LED       = NUM_LANES * BITS_PER_LANE - 1;
  localparam int SWAP_LO       = 13;
  localparam int SWAP_HI       = 14;
  localparam int STEP_W        = (BITS_PER_LANE > 1) ? $clog2(BITS_PER_LANE) : 1;
  localparam int TDATA_W       = 8;

  // write phases inside one bit step, and inside the latch tail
  localparam logic [1:0] PH_SETUP = 2'd0;
  localparam logic [1:0] PH_CLOCK = 2'd1;
  localparam logic [1:0] PH_HOLD  = 2'd2;
  localparam logic [1:0] PH_CLEAR = 2'd3;

  typedef logic [BITS_PER_LANE-1:0] lane_bits_t;

endpackage

// ===== src/parallel_shift_register_led_driver_top.sv =====
// LED chain driver top level: compares, stores and serializes an LED word.
// Depends on psrld_pkg for geometry and phase codes.
//
// A changed LED word produces 34 pin-write transfers on the master side, one per
// cycle while tready is high, the last one flagged by tlast; the input side takes
// no new word until the last write of the sequence has been issued. The sequence
// is set by the bit-step sequencer that shifts all four lane registers one bit
// every four writes. An unchanged word is taken and produces nothing. Each lane
// register is loaded MSB-step first from word bits 31-8p downward;
// swap_fix_enable, sampled at accept, exchanges LEDs 13 and 14. The stored word
// resets to all ones.
module parallel_shift_register_led_driver_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic                             cfg_wdata_i,     // swap_fix_enable
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  input  logic [psrld_pkg::WORD_W-1:0]     s_axis_tdata_i,  // [31:0] led_word
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // [3:0] lane_data, [4] shift_clock, [5] store_clock, [7:6] zero
  output logic [psrld_pkg::TDATA_W-1:0]    m_axis_tdata_o,
  output logic                             m_axis_tlast_o   // last_write
);
  import psrld_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic                         state_q, state_d;
  logic                         swap_q;
  logic [WORD_W-1:0]            shown_q;
  lane_bits_t                   lanes_q [NUM_LANES];
  lane_bits_t                   load_lanes [NUM_LANES];
  logic [1:0]                   phase_q;
  logic [STEP_W-1:0]            step_q;
  logic                         tail_q;
  logic                         out_valid_q;
  logic [LANE_DATA_W-1:0]       out_lane_q, lane_now;
  logic                         out_sclk_q, out_rclk_q, out_last_q;
  logic [WORD_W-1:0]            swapped;
  logic                         in_xfer, out_free, emit;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_xfer         = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign emit            = (state_q == ST_RUN) && out_free;

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {2'b00, out_rclk_q, out_sclk_q, out_lane_q};
  assign m_axis_tlast_o  = out_last_q;

  // swap the miswired pair in the word itself, then slice per lane
  always_comb begin
    swapped = s_axis_tdata_i;
    if (swap_q) begin
      swapped[SWAP_LO] = s_axis_tdata_i[SWAP_HI];
      swapped[SWAP_HI] = s_axis_tdata_i[SWAP_LO];
    end
  end

  always_comb begin
    int led;
    for (int p = 0; p < NUM_LANES; p++) begin
      for (int s = 0; s < BITS_PER_LANE; s++) begin
        led = TOP_LED - BITS_PER_LANE * p - s;
        load_lanes[p][s] = (led < WORD_W) ? swapped[led[4:0]] : 1'b0;
      end
    end
  end

  always_comb begin
    lane_now = '0;
    for (int p = 0; p < NUM_LANES; p++) begin
      if (p < LANE_DATA_W) lane_now[p] = lanes_q[p][0];
    end
  end

  always_comb begin
    state_d = state_q;
    if (in_xfer && (s_axis_tdata_i != shown_q)) state_d = ST_RUN;
    else if (emit && tail_q && (phase_q == PH_CLOCK)) state_d = ST_IDLE;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      swap_q      <= 1'b1;
      shown_q     <= '1;
      phase_q     <= PH_SETUP;
      step_q      <= '0;
      tail_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) swap_q <= cfg_wdata_i;
      if (in_xfer && (s_axis_tdata_i != shown_q)) begin
        shown_q <= s_axis_tdata_i;
        phase_q <= PH_SETUP;
        step_q  <= '0;
        tail_q  <= 1'b0;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
        if (tail_q && (phase_q == PH_CLOCK)) phase_q <= PH_SETUP;
        else                                 phase_q <= phase_q + 2'd1;
        if (!tail_q && (phase_q == PH_CLEAR)) begin
          step_q <= step_q + 1'b1;
          if (step_q == STEP_W'(BITS_PER_LANE - 1)) tail_q <= 1'b1;
        end
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // lane shift registers and output payload
  always_ff @(posedge clk_i) begin
    if (in_xfer && (s_axis_tdata_i != shown_q)) begin
      for (int p = 0; p < NUM_LANES; p++) lanes_q[p] <= load_lanes[p];
    end else if (emit && !tail_q && (phase_q == PH_CLEAR)) begin
      for (int p = 0; p < NUM_LANES; p++) lanes_q[p] <= lanes_q[p] >> 1;
    end
    if (emit) begin
      // lane data on setup, clock and hold; all lanes low on clear and in the latch tail
      out_lane_q <= (!tail_q && (phase_q != PH_CLEAR)) ? lane_now : '0;
      out_sclk_q <= !tail_q && (phase_q == PH_CLOCK);
      out_rclk_q <= tail_q && (phase_q == PH_SETUP);
      out_last_q <= tail_q && (phase_q != PH_SETUP);
    end
  end

endmodule

// ===== sim/tb_parallel_shift_register_led_driver_top.sv =====
// Self-checking testbench for the LED shift register chain driver.
// Depends on psrld_pkg and parallel_shift_register_led_driver_top; needs no files.
// Predicts each pin-write transfer and checks it, under random stalls on both sides.
module tb_parallel_shift_register_led_driver_top;
  timeunit 1ns;
  timeprecision 1ps;

  import psrld_pkg::*;

  localparam int WRITES_PER_WORD = 4 * BITS_PER_LANE + 2;
  localparam int PHASE_WORDS     = 75;
  localparam int N_DIR           = 23;

  typedef struct packed {
    logic [LANE_DATA_W-1:0] lanes;
    logic                   shift_clk;
    logic                   store_clk;
    logic                   last;
  } pin_write_t;

  typedef logic [LANE_DATA_W-1:0] lane_steps_t [BITS_PER_LANE];

  typedef struct packed {
    logic              wr_cfg;
    logic              cfg_val;
    logic [WORD_W-1:0] word;
    logic              typed;
    logic              changes;   // typed: a sequence is expected
    logic [3:0]        lanes;     // typed: lane data held over every step
  } dir_row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we = 1'b0;
  logic               cfg_wdata = 1'b0;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic [WORD_W-1:0]  s_tdata = '0;
  logic               m_tvalid;
  logic               m_tready = 1'b1;
  logic [TDATA_W-1:0] m_tdata;
  logic               m_tlast;

  // predictor state
  logic [WORD_W-1:0] shown_led_word;
  logic              swap_fix;

  pin_write_t pending_writes [$];
  int         error_count = 0;
  bit         idle_on = 1'b1;
  int         stall_left = 0;

  dir_row_t dir_rows [N_DIR] = '{
    '{1'b0, 1'b0, 32'hFFFF_FFFF, 1'b1, 1'b0, 4'h0},
    '{1'b0, 1'b0, 32'h0000_0000, 1'b1, 1'b1, 4'h0},
    '{1'b0, 1'b0, 32'h0000_0000, 1'b1, 1'b0, 4'h0},
    '{1'b0, 1'b0, 32'hFFFF_FFFF, 1'b1, 1'b1, 4'hF},
    '{1'b0, 1'b0, 32'h8000_0000, 1'b0, 1'b0, 4'h0},
    '{1'b0, 1'b0, 32'h0000_0001, 1'b0, 1'b0, 4'h0},
    '{1'b0, 1'b0, 32'h0000_2000, 1'b0, 1'b0, 4'h0},
    '{1'b0, 1'b0, 32'h0000_4000, 1'b0, 1'b0, 4'h0},
    '{1'b0, 1'b0, 32'h0000_6000, 1'b0, 1'b0, 4'h0},
    '{1'b0, 1'b0, 32'hFFFF_9FFF, 1'b0, 1'b0, 4'h0},
    '{1'b0, 1'b0, 32'hAAAA_AAAA, 1'b0, 1'b0, 4'h0},
    '{1'b0, 1'b0, 32'h5555_5555, 1'b0, 1'b0, 4'h0},
    '{1'b1, 1'b0, 32'h0000_2000, 1'b0, 1'b0, 4'h0},
    '{1'b0, 1'b0, 32'h0000_4000, 1'b0, 1'b0, 4'h0},
    '{1'b0, 1'b0, 32'hFFFF_9FFF, 1'b0, 1'b0, 4'h0},
    '{1'b0, 1'b0, 32'h0102_0408, 1'b0, 1'b0, 4'h0},
    '{1'b0, 1'b0, 32'h8040_2010, 1'b0, 1'b0, 4'h0},
    '{1'b0, 1'b0, 32'h1234_5678, 1'b0, 1'b0, 4'h0},
    '{1'b0, 1'b0, 32'h1234_5678, 1'b1, 1'b0, 4'h0},
    '{1'b1, 1'b1, 32'h0000_FFFF, 1'b0, 1'b0, 4'h0},
    '{1'b0, 1'b0, 32'hFFFF_0000, 1'b0, 1'b0, 4'h0},
    '{1'b1, 1'b0, 32'hFFFF_FFFF, 1'b1, 1'b1, 4'hF},
    '{1'b1, 1'b1, 32'h0000_0000, 1'b1, 1'b1, 4'h0}
  };

  parallel_shift_register_led_driver_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tlast_o  (m_tlast)
  );

  always #5 clk_i = ~clk_i;

  // Lane data per bit step for a word; advance the shown word when it changes.
  function automatic bit chain_lane_steps(input logic [WORD_W-1:0] w,
                                          output lane_steps_t steps);
    int led;
    for (int s = 0; s < BITS_PER_LANE; s++) begin
      steps[s] = '0;
      for (int p = 0; p < NUM_LANES; p++) begin
        led = TOP_LED - BITS_PER_LANE * p - s;
        if (swap_fix) begin
          if (led == SWAP_LO) led = SWAP_HI;
          else if (led == SWAP_HI) led = SWAP_LO;
        end
        if (led >= 0 && led < WORD_W && p < LANE_DATA_W && w[led]) steps[s][p] = 1'b1;
      end
    end
    if (w == shown_led_word) return 1'b0;
    shown_led_word = w;
    return 1'b1;
  endfunction

  function automatic void queue_pin_writes(input lane_steps_t steps);
    logic [1:0] ph;
    pin_write_t pw;
    for (int s = 0; s < BITS_PER_LANE; s++) begin
      for (int k = 0; k < 4; k++) begin
        ph = k[1:0];
        pw = '0;
        case (ph)
          PH_SETUP: pw.lanes = steps[s];
          PH_CLOCK: begin
            pw.lanes     = steps[s];
            pw.shift_clk = 1'b1;
          end
          PH_HOLD:  pw.lanes = steps[s];
          default:  pw = '0;
        endcase
        pending_writes.push_back(pw);
      end
    end
    pw = '0;
    pw.store_clk = 1'b1;
    pending_writes.push_back(pw);
    pw = '0;
    pw.last = 1'b1;
    pending_writes.push_back(pw);
  endfunction

  // Present one word, wait for its transfer, then queue what it should emit.
  // Typed rows replace the prediction with the values given in the table.
  task automatic send_word(input logic [WORD_W-1:0] w, input bit typed, input bit t_changes,
                           input logic [3:0] t_lanes);
    lane_steps_t steps;
    bit          changed;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 9)) begin
        @(negedge clk_i);
        s_tvalid = 1'b0;
      end
    end
    @(negedge clk_i);
    s_tvalid = 1'b1;
    s_tdata  = w;
    do @(posedge clk_i); while (!s_tready);
    changed = chain_lane_steps(w, steps);
    if (typed) begin
      changed = t_changes;
      for (int s = 0; s < BITS_PER_LANE; s++) steps[s] = t_lanes;
    end
    if (changed) queue_pin_writes(steps);
  endtask

  // Let the block go idle; an unchanged word may still be in flight.
  task automatic wait_idle();
    @(negedge clk_i);
    s_tvalid = 1'b0;
    while (pending_writes.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_swap(input logic v);
    wait_idle();
    @(negedge clk_i);
    cfg_we    = 1'b1;
    cfg_wdata = v;
    @(negedge clk_i);
    cfg_we    = 1'b0;
    swap_fix  = v;
  endtask

  task automatic run_random_phase(input logic swap_v, input bit idle_v);
    int          n_changed;
    logic [31:0] w;
    write_swap(swap_v);
    idle_on   = idle_v;
    n_changed = 0;
    while (n_changed < PHASE_WORDS) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: w = $urandom;
        4, 5:       w = shown_led_word ^ (32'h1 << $urandom_range(0, 31));
        6:          w = shown_led_word;
        7: begin
          w = $urandom & 32'hFFFF_9FFF;
          w[SWAP_LO] = 1'($urandom_range(0, 1));
          w[SWAP_HI] = 1'($urandom_range(0, 1));
        end
        8:          w = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
        default:    w = 32'h1 << $urandom_range(0, 31);
      endcase
      if (w != shown_led_word) n_changed++;
      send_word(w, 1'b0, 1'b0, 4'h0);
    end
  endtask

  // Receiver: stall in random bursts while idling is on.
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      m_tready = 1'b0;
      stall_left--;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      m_tready   = 1'b0;
      stall_left = $urandom_range(1, 9) - 1;
    end else begin
      m_tready = 1'b1;
    end
  end

  // Check each pin-write transfer against the oldest expectation.
  always @(posedge clk_i) begin
    pin_write_t got;
    pin_write_t want;
    if (rst_ni && m_tvalid && m_tready) begin
      got.lanes     = m_tdata[LANE_DATA_W-1:0];
      got.shift_clk = m_tdata[4];
      got.store_clk = m_tdata[5];
      got.last      = m_tlast;
      if (pending_writes.size() == 0) begin
        $display("%0t: unexpected pin write lanes=%h sclk=%b rclk=%b last=%b",
                 $time, got.lanes, got.shift_clk, got.store_clk, got.last);
        error_count++;
      end else begin
        want = pending_writes.pop_front();
        if (got.lanes != want.lanes || got.shift_clk != want.shift_clk ||
            got.store_clk != want.store_clk || got.last != want.last) begin
          $display("%0t: pin write mismatch expected lanes=%h sclk=%b rclk=%b last=%b",
                   $time, want.lanes, want.shift_clk, want.store_clk, want.last);
          $display("%0t:                    actual   lanes=%h sclk=%b rclk=%b last=%b",
                   $time, got.lanes, got.shift_clk, got.store_clk, got.last);
          error_count++;
        end
      end
    end
  end

  initial begin
    shown_led_word = '1;
    swap_fix       = 1'b1;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].wr_cfg) write_swap(dir_rows[i].cfg_val);
      send_word(dir_rows[i].word, dir_rows[i].typed, dir_rows[i].changes,
                dir_rows[i].lanes);
    end

    run_random_phase(1'b0, 1'b1);
    run_random_phase(1'b1, 1'b1);
    run_random_phase(1'b0, 1'b1);
    run_random_phase(1'b1, 1'b0);

    wait_idle();
    repeat (WRITES_PER_WORD + 10) @(posedge clk_i);
    if (pending_writes.size() != 0) begin
      $display("%0t: %0d pin writes never arrived", $time, pending_writes.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("** parallel_shift_register_led_driver_top: PASSED **");
    end else begin
      $display("** parallel_shift_register_led_driver_top: FAILED **");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("** parallel_shift_register_led_driver_top: FAILED **");
    $finish;
  end

endmodule
